// ===== rtl/core/rfp_pkg.sv =====
// package for the record format parser: item types, codes and state types
`timescale 1ns / 1ps

package rfp_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT     = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_IS_STRING = 2'd1;

    localparam logic [2:0] KIND_NULL     = 3'd0;
    localparam logic [2:0] KIND_INT      = 3'd1;
    localparam logic [2:0] KIND_STR_LEN  = 3'd2;
    localparam logic [2:0] KIND_STR_BYTE = 3'd3;
    localparam logic [2:0] KIND_OK       = 3'd4;
    localparam logic [2:0] KIND_ERROR    = 3'd5;

    localparam logic [1:0] ERR_BITMAP  = 2'd0;
    localparam logic [1:0] ERR_INT     = 2'd1;
    localparam logic [1:0] ERR_LENGTH  = 2'd2;
    localparam logic [1:0] ERR_CONTENT = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [4:0]  column;
        logic [31:0] value;
        logic [1:0]  error_code;
        logic        last;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_BITMAP,
        PH_INT,
        PH_LEN,
        PH_CONTENT,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_ADV,
        ST_FINAL
    } t_state;

endpackage

// ===== rtl/core/record_format_parser.sv =====
// record format parser: null bitmap row record decoder, one byte per input item
//
//  channel  dir  handshake                   payload
//  in       in   i_in_valid / o_in_ready     i_in_item  (rfp_pkg::t_in_item)
//  out      out  o_out_valid / i_out_ready   o_out_item (rfp_pkg::t_out_item)
//  cfg      in   i_cfg_we                    i_cfg_index, i_cfg_data
//
//  a byte that completes an int, length or content result passes through an emit state
//  once the bitmap or a column is finished the column sequencer emits a null item for each
//  null column and then moves on to the next present column or the end of the schema
//  a final byte leads to a final state for the ok/error item; words shift in a byte per cycle
//  synchronous active-low reset clears the schema to one int column
//  a stalled output holds the sequencer, input is taken only when it is idle
`timescale 1ns / 1ps

module record_format_parser #(
    parameter int MAX_COLUMNS = rfp_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  rfp_pkg::t_in_item                i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output rfp_pkg::t_out_item               o_out_item,
    input  logic                             i_cfg_we,
    input  logic [rfp_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [rfp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int         LP_COLS   = (MAX_COLUMNS < 32) ? MAX_COLUMNS : 32;
    localparam logic [5:0] LP_COLS_W = 6'(LP_COLS);

    logic [5:0]          r_count;
    logic [31:0]         r_is_str;
    rfp_pkg::t_state     r_state, n_state;
    rfp_pkg::t_phase     r_phase, n_phase;
    logic [5:0]          r_col, n_col;
    logic [2:0]          r_bc, n_bc;
    logic [31:0]         r_gather, n_gather;
    logic [31:0]         r_rem, n_rem;
    logic [LP_COLS-1:0]  r_null, n_null;
    logic [7:0]          r_byte, n_byte;
    logic                r_fin, n_fin;
    logic                r_ov, n_ov;
    rfp_pkg::t_out_item  r_out, n_out;

    logic [5:0]          w_cnt;
    logic [2:0]          w_need;
    logic                w_slot;
    logic [31:0]         w_null32;
    logic [LP_COLS-1:0]  w_lane;
    rfp_pkg::t_state     w_after_in;
    rfp_pkg::t_state     w_after;
    rfp_pkg::t_phase     w_ph;
    logic [2:0]          w_bcx;

    always_comb begin
        if (r_count == 6'd0) begin
            w_cnt = 6'd1;
        end else if (r_count > LP_COLS_W) begin
            w_cnt = LP_COLS_W;
        end else begin
            w_cnt = r_count;
        end
        w_need = 3'((7'(w_cnt) + 7'd7) >> 3);
    end

    assign w_slot     = !r_ov || i_out_ready;
    assign w_null32   = 32'(r_null);
    assign w_after_in = i_in_item.final_byte ? rfp_pkg::ST_FINAL : rfp_pkg::ST_IDLE;
    assign w_after    = r_fin ? rfp_pkg::ST_FINAL : rfp_pkg::ST_IDLE;

    // byte lane of the bitmap selected by the bitmap byte count
    always_comb begin
        for (int i = 0; i < LP_COLS; i++) begin
            w_lane[i] = ((i >> 3) == int'(r_bc)) ? i_in_item.data_byte[i & 7] : 1'b0;
        end
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_col    = r_col;
        n_bc     = r_bc;
        n_gather = r_gather;
        n_rem    = r_rem;
        n_null   = r_null;
        n_byte   = r_byte;
        n_fin    = r_fin;
        n_ov     = r_ov && !i_out_ready;
        n_out    = r_out;
        w_ph     = r_phase;
        w_bcx    = r_bc;

        unique case (r_state)
            rfp_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_byte = i_in_item.data_byte;
                    n_fin  = i_in_item.final_byte;
                    if ((r_phase == rfp_pkg::PH_INT || r_phase == rfp_pkg::PH_LEN ||
                         r_phase == rfp_pkg::PH_CONTENT) && r_col >= w_cnt) begin
                        w_ph = rfp_pkg::PH_DONE;
                    end
                    n_phase = w_ph;
                    unique case (w_ph)
                        rfp_pkg::PH_BITMAP: begin
                            if (r_bc < w_need) begin
                                n_null = r_null | w_lane;
                                w_bcx  = r_bc + 3'd1;
                            end
                            n_bc = w_bcx;
                            if (w_bcx >= w_need) begin
                                n_col   = 6'd0;
                                n_state = rfp_pkg::ST_ADV;
                            end else begin
                                n_state = w_after_in;
                            end
                        end
                        rfp_pkg::PH_INT, rfp_pkg::PH_LEN: begin
                            n_gather = {i_in_item.data_byte, r_gather[31:8]};
                            n_bc     = r_bc + 3'd1;
                            n_state  = (r_bc == 3'd3) ? rfp_pkg::ST_EMIT : w_after_in;
                        end
                        rfp_pkg::PH_CONTENT: begin
                            n_state = rfp_pkg::ST_EMIT;
                        end
                        rfp_pkg::PH_DONE: begin
                            n_state = w_after_in;
                        end
                        default: begin
                            n_state = w_after_in;
                        end
                    endcase
                end
            end
            rfp_pkg::ST_EMIT: begin
                if (w_slot) begin
                    n_ov             = 1'b1;
                    n_out.column     = r_col[4:0];
                    n_out.error_code = rfp_pkg::ERR_BITMAP;
                    n_out.last       = 1'b0;
                    unique case (r_phase)
                        rfp_pkg::PH_INT: begin
                            n_out.kind  = rfp_pkg::KIND_INT;
                            n_out.value = r_gather;
                            n_col       = r_col + 6'd1;
                            n_state     = rfp_pkg::ST_ADV;
                        end
                        rfp_pkg::PH_LEN: begin
                            n_out.kind  = rfp_pkg::KIND_STR_LEN;
                            n_out.value = r_gather;
                            n_rem       = r_gather;
                            n_bc        = 3'd0;
                            if (r_gather == 32'd0) begin
                                n_col   = r_col + 6'd1;
                                n_state = rfp_pkg::ST_ADV;
                            end else begin
                                n_phase = rfp_pkg::PH_CONTENT;
                                n_state = w_after;
                            end
                        end
                        rfp_pkg::PH_CONTENT: begin
                            n_out.kind  = rfp_pkg::KIND_STR_BYTE;
                            n_out.value = {24'd0, r_byte};
                            n_rem       = r_rem - 32'd1;
                            if (r_rem == 32'd1) begin
                                n_col   = r_col + 6'd1;
                                n_state = rfp_pkg::ST_ADV;
                            end else begin
                                n_state = w_after;
                            end
                        end
                        default: begin
                            n_ov    = r_ov && !i_out_ready;
                            n_out   = r_out;
                            n_state = w_after;
                        end
                    endcase
                end
            end
            rfp_pkg::ST_ADV: begin
                if (r_col >= w_cnt) begin
                    n_phase = rfp_pkg::PH_DONE;
                    n_state = w_after;
                end else if (w_null32[r_col[4:0]]) begin
                    if (w_slot) begin
                        n_ov             = 1'b1;
                        n_out.kind       = rfp_pkg::KIND_NULL;
                        n_out.column     = r_col[4:0];
                        n_out.value      = 32'd0;
                        n_out.error_code = rfp_pkg::ERR_BITMAP;
                        n_out.last       = 1'b0;
                        n_col            = r_col + 6'd1;
                    end
                end else begin
                    n_phase  = r_is_str[r_col[4:0]] ? rfp_pkg::PH_LEN : rfp_pkg::PH_INT;
                    n_bc     = 3'd0;
                    n_gather = 32'd0;
                    n_state  = w_after;
                end
            end
            rfp_pkg::ST_FINAL: begin
                if (w_slot) begin
                    n_ov        = 1'b1;
                    n_out.value = 32'd0;
                    n_out.last  = 1'b1;
                    unique case (r_phase)
                        rfp_pkg::PH_DONE: begin
                            n_out.kind       = rfp_pkg::KIND_OK;
                            n_out.column     = 5'd0;
                            n_out.error_code = rfp_pkg::ERR_BITMAP;
                        end
                        rfp_pkg::PH_BITMAP: begin
                            n_out.kind       = rfp_pkg::KIND_ERROR;
                            n_out.column     = 5'd0;
                            n_out.error_code = rfp_pkg::ERR_BITMAP;
                        end
                        rfp_pkg::PH_INT: begin
                            n_out.kind       = rfp_pkg::KIND_ERROR;
                            n_out.column     = r_col[4:0];
                            n_out.error_code = rfp_pkg::ERR_INT;
                        end
                        rfp_pkg::PH_LEN: begin
                            n_out.kind       = rfp_pkg::KIND_ERROR;
                            n_out.column     = r_col[4:0];
                            n_out.error_code = rfp_pkg::ERR_LENGTH;
                        end
                        default: begin
                            n_out.kind       = rfp_pkg::KIND_ERROR;
                            n_out.column     = r_col[4:0];
                            n_out.error_code = rfp_pkg::ERR_CONTENT;
                        end
                    endcase
                    n_phase  = rfp_pkg::PH_BITMAP;
                    n_col    = 6'd0;
                    n_bc     = 3'd0;
                    n_gather = 32'd0;
                    n_rem    = 32'd0;
                    n_null   = '0;
                    n_fin    = 1'b0;
                    n_state  = rfp_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rfp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= rfp_pkg::ST_IDLE;
            r_phase  <= rfp_pkg::PH_BITMAP;
            r_col    <= 6'd0;
            r_bc     <= 3'd0;
            r_gather <= 32'd0;
            r_rem    <= 32'd0;
            r_null   <= '0;
            r_fin    <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_col    <= n_col;
            r_bc     <= n_bc;
            r_gather <= n_gather;
            r_rem    <= n_rem;
            r_null   <= n_null;
            r_fin    <= n_fin;
            r_ov     <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_out  <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= 6'd1;
            r_is_str <= 32'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == rfp_pkg::CFG_COLUMN_COUNT) begin
                r_count <= i_cfg_data[5:0];
            end else if (i_cfg_index == rfp_pkg::CFG_COLUMN_IS_STRING) begin
                r_is_str <= i_cfg_data;
            end
        end
    end

    assign o_in_ready  = (r_state == rfp_pkg::ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

endmodule

// ===== test/record_format_parser_tb.sv =====
// testbench for record_format_parser: directed and random records against a decoder model
`timescale 1ns / 1ps

module record_format_parser_tb;

    localparam int COLUMNS_LIMIT =
        (rfp_pkg::MAX_COLUMNS_DEFAULT < 32) ? rfp_pkg::MAX_COLUMNS_DEFAULT : 32;
    localparam logic [1:0] NO_ERROR = 2'd0;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_BYTES = 42;
    localparam int STRING_BYTES = 8;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    rfp_pkg::t_in_item                i_in_item = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    rfp_pkg::t_out_item               o_out_item;
    logic                             i_cfg_we = 1'b0;
    logic [rfp_pkg::CFG_INDEX_W-1:0]  i_cfg_index = '0;
    logic [rfp_pkg::CFG_DATA_W-1:0]   i_cfg_data = '0;

    // schema and record state of the decoder model
    logic [5:0]       sch_count;
    logic [31:0]      sch_strings;
    logic [31:0]      rec_nulls;
    rfp_pkg::t_phase  rec_phase;
    int unsigned      rec_col;
    int unsigned      rec_bytes;
    logic [31:0]      rec_word;
    logic [31:0]      rec_left;

    rfp_pkg::t_out_item  awaited_results[$];
    logic [7:0]          record_bytes[$];

    int  mismatches = 0;
    int  results_checked = 0;
    int  bytes_taken = 0;
    int  records_sent = 0;
    bit  calm = 1'b0;
    int  hold_request = 0;

    record_format_parser dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int unsigned live_column_count();
        int unsigned c;
        c = sch_count;
        if (c == 0) c = 1;
        if (c > COLUMNS_LIMIT) c = COLUMNS_LIMIT;
        return c;
    endfunction

    function automatic void clear_record_state();
        rec_nulls = '0;
        rec_phase = rfp_pkg::PH_BITMAP;
        rec_col = 0;
        rec_bytes = 0;
        rec_word = '0;
        rec_left = '0;
    endfunction

    function automatic void add_byte(logic [7:0] b);
        record_bytes = {record_bytes, b};
    endfunction

    function automatic void trim_record(int keep);
        while (record_bytes.size() > keep && record_bytes.size() > 1)
            void'(record_bytes.pop_back());
    endfunction

    function automatic void queue_result(logic [2:0] kind, int unsigned col, logic [31:0] value,
                                         logic [1:0] err, logic last);
        rfp_pkg::t_out_item r;
        r.kind = kind;
        r.column = col[4:0];
        r.value = value;
        r.error_code = err;
        r.last = last;
        awaited_results = {awaited_results, r};
    endfunction

    // emit nulls from the current column on, stop at the next present one or the end of the schema
    function automatic void walk_null_columns();
        int unsigned cnt;
        cnt = live_column_count();
        while (rec_col < cnt) begin
            if (rec_nulls[rec_col % 32]) begin
                queue_result(rfp_pkg::KIND_NULL, rec_col, '0, NO_ERROR, 1'b0);
                rec_col++;
            end else begin
                rec_phase = sch_strings[rec_col % 32] ? rfp_pkg::PH_LEN : rfp_pkg::PH_INT;
                rec_bytes = 0;
                rec_word = '0;
                return;
            end
        end
        rec_phase = rfp_pkg::PH_DONE;
    endfunction

    function automatic void decode_record_byte(rfp_pkg::t_in_item it);
        int unsigned cnt;
        int unsigned need;
        logic [1:0]  code;
        cnt = live_column_count();
        if (rec_phase != rfp_pkg::PH_DONE && rec_phase != rfp_pkg::PH_BITMAP && rec_col >= cnt)
            rec_phase = rfp_pkg::PH_DONE;
        case (rec_phase)
            rfp_pkg::PH_BITMAP: begin
                need = (cnt + 7) / 8;
                if (rec_bytes < need) begin
                    rec_nulls |= 32'(it.data_byte) << (8 * (rec_bytes % 4));
                    rec_bytes++;
                end
                if (rec_bytes >= need) begin
                    rec_col = 0;
                    walk_null_columns();
                end
            end
            rfp_pkg::PH_INT, rfp_pkg::PH_LEN: begin
                rec_word |= 32'(it.data_byte) << (8 * (rec_bytes % 4));
                rec_bytes++;
                if (rec_bytes >= 4) begin
                    if (rec_phase == rfp_pkg::PH_INT) begin
                        queue_result(rfp_pkg::KIND_INT, rec_col, rec_word, NO_ERROR, 1'b0);
                        rec_col++;
                        walk_null_columns();
                    end else begin
                        queue_result(rfp_pkg::KIND_STR_LEN, rec_col, rec_word, NO_ERROR, 1'b0);
                        rec_left = rec_word;
                        rec_bytes = 0;
                        if (rec_left == 0) begin
                            rec_col++;
                            walk_null_columns();
                        end else begin
                            rec_phase = rfp_pkg::PH_CONTENT;
                        end
                    end
                end
            end
            rfp_pkg::PH_CONTENT: begin
                queue_result(rfp_pkg::KIND_STR_BYTE, rec_col, 32'(it.data_byte), NO_ERROR, 1'b0);
                rec_left--;
                if (rec_left == 0) begin
                    rec_col++;
                    walk_null_columns();
                end
            end
            default: ;
        endcase
        if (it.final_byte) begin
            if (rec_phase == rfp_pkg::PH_DONE) begin
                queue_result(rfp_pkg::KIND_OK, 0, '0, NO_ERROR, 1'b1);
            end else if (rec_phase == rfp_pkg::PH_BITMAP) begin
                queue_result(rfp_pkg::KIND_ERROR, 0, '0, rfp_pkg::ERR_BITMAP, 1'b1);
            end else begin
                code = (rec_phase == rfp_pkg::PH_INT) ? rfp_pkg::ERR_INT :
                       (rec_phase == rfp_pkg::PH_LEN) ? rfp_pkg::ERR_LENGTH :
                       rfp_pkg::ERR_CONTENT;
                queue_result(rfp_pkg::KIND_ERROR, rec_col, '0, code, 1'b1);
            end
            clear_record_state();
        end
    endfunction

    // model follows register writes and accepted items
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sch_count = 6'd1;
            sch_strings = '0;
            clear_record_state();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rfp_pkg::CFG_COLUMN_COUNT) sch_count = i_cfg_data[5:0];
                else if (i_cfg_index == rfp_pkg::CFG_COLUMN_IS_STRING) sch_strings = i_cfg_data;
            end
            if (i_in_valid && o_in_ready) begin
                decode_record_byte(i_in_item);
                bytes_taken++;
            end
        end
    end

    task automatic report_mismatch(input string why, input rfp_pkg::t_out_item got,
                                   input rfp_pkg::t_out_item want);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: got kind %0d col %0d value %h err %0d last %0b",
                     $time, why, got.kind, got.column, got.value, got.error_code, got.last);
            $display("    wanted kind %0d col %0d value %h err %0d last %0b",
                     want.kind, want.column, want.value, want.error_code, want.last);
        end
    endtask

    rfp_pkg::t_out_item want_item;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("unexpected result", o_out_item, '0);
            end else begin
                want_item = awaited_results.pop_front();
                if (o_out_item.kind !== want_item.kind ||
                    o_out_item.column !== want_item.column ||
                    o_out_item.value !== want_item.value ||
                    o_out_item.error_code !== want_item.error_code ||
                    o_out_item.last !== want_item.last)
                    report_mismatch("wrong result", o_out_item, want_item);
            end
            results_checked++;
        end
    end

    // receiver: random stalls, always ready while calm, or a counted hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request > 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                i_out_ready <= 1'b0;
                hold_left--;
            end else if (calm) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= 16);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        rfp_pkg::t_in_item it;
        if (!calm && $urandom_range(99) < 16) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        it.data_byte = b;
        it.final_byte = fin;
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_record(input int final_pct);
        logic fin;
        for (int i = 0; i < record_bytes.size(); i++) begin
            fin = (i == record_bytes.size() - 1) || ($urandom_range(99) < final_pct);
            send_byte(record_bytes[i], fin);
        end
        records_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [rfp_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [rfp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic program_schema(input logic [31:0] count, input logic [31:0] strings);
        drain_results();
        write_reg(rfp_pkg::CFG_COLUMN_COUNT, count);
        write_reg(rfp_pkg::CFG_COLUMN_IS_STRING, strings);
    endtask

    task automatic load_bytes(input logic [7:0] b0, input int n, input logic [127:0] rest);
        record_bytes.delete();
        add_byte(b0);
        for (int i = 0; i < n; i++) add_byte(rest[8*i +: 8]);
    endtask

    // well-formed record for a schema of cols columns
    task automatic build_record(input int unsigned cols, input logic [31:0] strings,
                                input int null_pct, input int max_len);
        logic [31:0] nulls;
        logic [31:0] word;
        int unsigned len;
        record_bytes.delete();
        for (int i = 0; i < 32; i++)
            nulls[i] = (i < cols) ? ($urandom_range(99) < null_pct) : 1'($urandom_range(1));
        for (int b = 0; b < (cols + 7) / 8; b++) add_byte(nulls[8*b +: 8]);
        for (int i = 0; i < cols; i++) begin
            if (!nulls[i]) begin
                len = $urandom_range(max_len);
                word = strings[i] ? len : $urandom;
                for (int k = 0; k < 4; k++) add_byte(word[8*k +: 8]);
                if (strings[i])
                    repeat (len) add_byte(8'($urandom_range(255)));
            end
        end
        repeat ($urandom_range(2)) add_byte(8'($urandom_range(255)));
    endtask

    task automatic test_default_schema();
        load_bytes(8'h00, 4, 128'hDEAD_BEEF);
        send_record(0);
    endtask

    task automatic test_mixed_columns();
        program_schema(3, 32'b010);
        record_bytes = '{8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01, 8'h00, 8'h00, 8'h00,
                         8'h80, 8'h5A, 8'h00};
        send_record(0);
    endtask

    task automatic test_short_records();
        program_schema(0, 32'h0);
        record_bytes = '{8'h00, 8'h12};
        send_record(0);
        program_schema(0, 32'h1);
        record_bytes = '{8'h00, 8'h01};
        send_record(0);
        program_schema(32'hFFFF_FFFF, 32'h1);
        record_bytes = '{8'hFF};
        send_record(0);
    endtask

    task automatic test_empty_string_and_cut_content();
        program_schema(2, 32'b11);
        record_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05, 8'h00, 8'h00, 8'h00, 8'hAA};
        send_record(0);
    endtask

    task automatic test_schema_change_mid_record();
        program_schema(9, 32'h0);
        send_byte(8'h00, 1'b0);
        drain_results();
        write_reg(rfp_pkg::CFG_COLUMN_COUNT, 4);
        record_bytes = '{8'h55, 8'h01, 8'h02, 8'h03, 8'h84, 8'h7F, 8'h80};
        foreach (record_bytes[i]) send_byte(record_bytes[i], 1'b0);
        drain_results();
        write_reg(rfp_pkg::CFG_COLUMN_COUNT, 1);
        send_byte(8'h77, 1'b1);
        records_sent++;
    endtask

    task automatic test_all_null_wide();
        program_schema(32, 32'hFFFF_FFFF);
        record_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_record(0);
    endtask

    task automatic test_backpressure();
        program_schema(1, 32'h1);
        hold_request = 150;
        record_bytes = '{8'h00, 8'(STRING_BYTES), 8'h00, 8'h00, 8'h00};
        repeat (STRING_BYTES) add_byte(8'($urandom_range(255)));
        send_record(0);
        // sender waits for everything before going on
        drain_results();
    endtask

    task automatic test_random_records();
        int start;
        int pick;
        int budget;
        int unsigned cnt;
        int unsigned cols;
        logic [31:0] strings;
        start = bytes_taken;
        cnt = 1;
        strings = 0;
        while (bytes_taken - start < RANDOM_BYTES) begin
            calm = (bytes_taken - start >= 10) && (bytes_taken - start < 34);
            if (($urandom_range(2) == 0) || (cnt == 1 && strings == 0)) begin
                pick = $urandom_range(99);
                cnt = (pick < 70) ? $urandom_range(6, 1) :
                      (pick < 88) ? $urandom_range(32, 7) :
                      (pick < 94) ? 0 : $urandom_range(63, 33);
                strings = $urandom;
                program_schema({8'($urandom_range(255)), 18'h0, 6'(cnt)}, strings);
            end
            cols = (cnt == 0) ? 1 : (cnt > COLUMNS_LIMIT) ? COLUMNS_LIMIT : cnt;
            budget = RANDOM_BYTES - (bytes_taken - start);
            pick = $urandom_range(99);
            if (pick < 10) begin
                record_bytes.delete();
                repeat ($urandom_range(6, 1)) add_byte(8'($urandom_range(255)));
                trim_record(budget);
                send_record(30);
            end else begin
                build_record(cols, strings, $urandom_range(60),
                             ($urandom_range(9) == 0) ? 12 : 3);
                if (pick < 25 && record_bytes.size() > 1)
                    trim_record($urandom_range(record_bytes.size() - 1, 1));
                trim_record(budget);
                send_record(0);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_default_schema();
        test_mixed_columns();
        test_short_records();
        test_empty_string_and_cut_content();
        test_schema_change_mid_record();
        test_all_null_wide();
        test_backpressure();
        test_random_records();
        drain_results();
        $display("decoded %0d records from %0d bytes, %0d results checked",
                 records_sent, bytes_taken, results_checked);
        $display("schemas from 1 to 32 columns, short records, mid-record writes and output hold-off");
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", awaited_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rfp_pkg.sv
rtl/core/record_format_parser.sv
test/record_format_parser_tb.sv
